### design/capc_pkg.sv
// ----------------------------------------------------------------------------
// capc_pkg: shared types and constants for the packet airtime calculator
// Holds the register index codes, the low data rate mode codes, the datapath
// widths, the lane record that walks down the divider chain and the table of
// reciprocals used for the symbol block count.
// ----------------------------------------------------------------------------
package capc_pkg;

   // Quotient bits of the long divider, one bit per cell of the chain.
   localparam int DIV_W   = 41;
   // Remainder width: the divisor 4*bw stays below 2048.
   localparam int REM_W   = 11;
   localparam int PS_W    = 11;
   localparam int X_W     = 10;
   localparam int RECIP_W = 15;
   localparam int RECIP_SHIFT = 16;
   localparam int BLK_W   = 8;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_SPREADING_FACTOR  = 3'd0;
   localparam logic [2:0] REG_BANDWIDTH_KHZ     = 3'd1;
   localparam logic [2:0] REG_CODING_RATE_INDEX = 3'd2;
   localparam logic [2:0] REG_LOW_RATE_MODE     = 3'd3;
   localparam logic [2:0] REG_EXPLICIT_HEADER   = 3'd4;
   localparam logic [2:0] REG_PREAMBLE_SYMBOLS  = 3'd5;

   // Low data rate optimization modes.
   localparam logic [1:0] LDR_AUTO = 2'd0;
   localparam logic [1:0] LDR_ON   = 2'd1;
   localparam logic [1:0] LDR_OFF  = 2'd2;

   // Configuration after range limiting, as the datapath uses it.
   typedef struct packed {
      logic [3:0]  sf;
      logic [8:0]  bw;
      logic [2:0]  cr;
      logic        de;
      logic        h;
      logic [15:0] pre;
   } cfg_type;

   // One item in flight through the divider chain. Each dq field starts as
   // the dividend and fills from the bottom with quotient bits.
   typedef struct packed {
      logic [REM_W-1:0] rem_ms;
      logic [DIV_W-1:0] dq_ms;
      logic [REM_W-1:0] rem_us;
      logic [DIV_W-1:0] dq_us;
      logic [PS_W-1:0]  ps;
   } lane_type;

   // Rounded-up 2^16/d, exact for every dividend below 1024 and d in 4..12.
   function automatic logic [RECIP_W-1:0] recip(input logic [3:0] d);
      logic [RECIP_W-1:0] m;
      case (d)
         4'd4:    m = 15'd16384;
         4'd5:    m = 15'd13108;
         4'd6:    m = 15'd10923;
         4'd7:    m = 15'd9363;
         4'd8:    m = 15'd8192;
         4'd9:    m = 15'd7282;
         4'd10:   m = 15'd6554;
         4'd11:   m = 15'd5958;
         4'd12:   m = 15'd5462;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

### design/capc_front.sv
// ----------------------------------------------------------------------------
// capc_front: symbol count and dividend preparation
// Four registered stages turn a payload length into the payload symbol count
// and the two dividends (ms and us scaled) that the divider chain consumes.
// ----------------------------------------------------------------------------
module capc_front (
   input  logic               clock,
   input  logic               reset,
   input  capc_pkg::cfg_type  cfg,
   input  logic               in_valid,
   input  logic [7:0]         in_bytes,
   output logic               in_ready,
   output logic               out_valid,
   output capc_pkg::lane_type out_lane,
   input  logic               out_ready
);

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s4_valid_ff, s4_valid_in;
   logic rdy1, rdy2, rdy3, rdy4;

   logic [capc_pkg::X_W-1:0]   s1_x_ff, s1_x_in;
   logic [3:0]                 s1_d_ff, s1_d_in;
   logic [capc_pkg::BLK_W-1:0] s2_blk_ff, s2_blk_in;
   logic [capc_pkg::PS_W-1:0]  s3_ps_ff, s3_ps_in;
   capc_pkg::lane_type         s4_lane_ff, s4_lane_in;

   logic signed [12:0] num;
   logic [12:0]        ceil_sum;
   logic [24:0]        prod;
   logic [11:0]        blk_mult;
   logic [11:0]        ps_sum;
   logic [16:0]        pre_ps;
   logic [18:0]        base;
   logic [30:0]        quarter;
   logic [capc_pkg::DIV_W-1:0] quarter_w;
   logic [capc_pkg::DIV_W-1:0] us_dividend;

   // A stage moves on when it is empty or its successor takes its item.
   assign rdy4     = !s4_valid_ff || out_ready;
   assign rdy3     = !s3_valid_ff || rdy4;
   assign rdy2     = !s2_valid_ff || rdy3;
   assign rdy1     = !s1_valid_ff || rdy2;
   assign in_ready = rdy1;

   // Stage one: numerator, rounded-up quarter and symbol divisor.
   always_comb begin
      num = $signed({2'b00, in_bytes, 3'b000}) - $signed({7'b0, cfg.sf, 2'b00})
            + 13'sd44 - (cfg.h ? 13'sd20 : 13'sd0);
      s1_d_in  = cfg.sf - {2'b00, cfg.de, 1'b0};
      ceil_sum = num + {7'b0, s1_d_in, 2'b00} - 13'd1;
      s1_x_in  = (num > 13'sd0) ? ceil_sum[11:2] : '0;
   end

   // Stage two: block count by reciprocal multiplication.
   always_comb begin
      prod      = {10'b0, s1_x_ff} * {10'b0, capc_pkg::recip(s1_d_ff)};
      s2_blk_in = prod[capc_pkg::RECIP_SHIFT +: capc_pkg::BLK_W];
   end

   // Stage three: payload symbols, eight fixed plus the coded blocks.
   always_comb begin
      blk_mult = {4'b0, s2_blk_ff} * ({9'b0, cfg.cr} + 12'd4);
      ps_sum   = blk_mult + 12'd8;
      s3_ps_in = ps_sum[capc_pkg::PS_W-1:0];
   end

   // Stage four: airtime in quarter symbols times chips, and times 1000.
   always_comb begin
      pre_ps      = {1'b0, cfg.pre} + {6'b0, s3_ps_ff};
      base        = {pre_ps, 2'b00} + 19'd17;
      quarter     = {12'b0, base} << cfg.sf;
      quarter_w   = {10'b0, quarter};
      us_dividend = (quarter_w << 10) - (quarter_w << 4) - (quarter_w << 3);
      s4_lane_in.rem_ms = '0;
      s4_lane_in.dq_ms  = quarter_w;
      s4_lane_in.rem_us = '0;
      s4_lane_in.dq_us  = us_dividend;
      s4_lane_in.ps     = s3_ps_ff;
   end

   // Valid bits of the four stages.
   always_comb begin
      s1_valid_in = rdy1 ? in_valid    : s1_valid_ff;
      s2_valid_in = rdy2 ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = rdy3 ? s2_valid_ff : s3_valid_ff;
      s4_valid_in = rdy4 ? s3_valid_ff : s4_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   // Payload registers load only when an item moves in.
   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         s1_x_ff <= s1_x_in;
         s1_d_ff <= s1_d_in;
      end
      if (rdy2 && s1_valid_ff) begin
         s2_blk_ff <= s2_blk_in;
      end
      if (rdy3 && s2_valid_ff) begin
         s3_ps_ff <= s3_ps_in;
      end
      if (rdy4 && s3_valid_ff) begin
         s4_lane_ff <= s4_lane_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_lane  = s4_lane_ff;

endmodule

### design/capc_div_cell.sv
// ----------------------------------------------------------------------------
// capc_div_cell: one restoring division step for both airtime lanes
// Shifts the top dividend bit into the remainder, subtracts the divisor when
// it fits and shifts the quotient bit in at the bottom, then hands the item
// on to the next cell.
// ----------------------------------------------------------------------------
module capc_div_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [capc_pkg::REM_W-1:0]  divisor,
   input  logic                        in_valid,
   input  capc_pkg::lane_type          in_lane,
   output logic                        in_ready,
   output logic                        out_valid,
   output capc_pkg::lane_type          out_lane,
   input  logic                        out_ready
);

   logic               valid_ff, valid_in;
   capc_pkg::lane_type lane_ff, lane_in;
   logic [capc_pkg::REM_W:0] div_ext;
   logic [capc_pkg::REM_W:0] t_ms, t_us, d_ms, d_us;
   logic                     q_ms, q_us;

   assign in_ready = !valid_ff || out_ready;

   // One quotient bit per lane.
   always_comb begin
      div_ext = {1'b0, divisor};
      t_ms    = {in_lane.rem_ms, in_lane.dq_ms[capc_pkg::DIV_W-1]};
      t_us    = {in_lane.rem_us, in_lane.dq_us[capc_pkg::DIV_W-1]};
      d_ms    = t_ms - div_ext;
      d_us    = t_us - div_ext;
      q_ms    = (t_ms >= div_ext);
      q_us    = (t_us >= div_ext);
      lane_in.rem_ms = q_ms ? d_ms[capc_pkg::REM_W-1:0] : t_ms[capc_pkg::REM_W-1:0];
      lane_in.rem_us = q_us ? d_us[capc_pkg::REM_W-1:0] : t_us[capc_pkg::REM_W-1:0];
      lane_in.dq_ms  = {in_lane.dq_ms[capc_pkg::DIV_W-2:0], q_ms};
      lane_in.dq_us  = {in_lane.dq_us[capc_pkg::DIV_W-2:0], q_us};
      lane_in.ps     = in_lane.ps;
      valid_in       = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

### design/chirp_packet_airtime_calc.sv
// ----------------------------------------------------------------------------
// chirp_packet_airtime_calc: packet symbol count and time on air
// Top level: configuration registers, range limiting, the front stages and
// the chain of division cells that yields the ms and us airtimes.
// ----------------------------------------------------------------------------
// The block takes payload lengths and returns the payload symbol count and the
// exact floored time on air in milliseconds and microseconds, both saturating
// at the 32-bit maximum. The path is four front stages (numerator, block count,
// symbol count, dividend scaling) plus a chain of 41 division cells that each
// produce one quotient bit of the division by four times the bandwidth, for
// both units side by side. A new item can enter every cycle while rsp_stall is
// low, and an item is still taken while a result waits, as long as some stage
// of the chain is free. Configuration takes effect at once and should be
// written only while no item is in flight; there is no clearing pass.
module chirp_packet_airtime_calc (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_payload_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [10:0] rsp_payload_symbols,
   output logic [31:0] rsp_airtime_ms,
   output logic [31:0] rsp_airtime_us,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int W = capc_pkg::DIV_W;

   logic [3:0]  sf_ff,  sf_in;
   logic [8:0]  bw_ff,  bw_in;
   logic [2:0]  cr_ff,  cr_in;
   logic [1:0]  ldr_ff, ldr_in;
   logic        hdr_ff, hdr_in;
   logic [15:0] pre_ff, pre_in;

   capc_pkg::cfg_type          cfg;
   logic [capc_pkg::REM_W-1:0] divisor;
   logic                       front_ready;

   capc_pkg::lane_type lane [0:W];
   logic [W:0]         lane_valid;
   logic [W:0]         lane_ready;

   logic [W-1:0] q_ms, q_us;

   // Register writes; indexes past the list are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      sf_in  = sf_ff;
      bw_in  = bw_ff;
      cr_in  = cr_ff;
      ldr_in = ldr_ff;
      hdr_in = hdr_ff;
      pre_in = pre_ff;
      if (csr_valid) begin
         unique case (csr_index)
            capc_pkg::REG_SPREADING_FACTOR:  sf_in  = csr_data[3:0];
            capc_pkg::REG_BANDWIDTH_KHZ:     bw_in  = csr_data[8:0];
            capc_pkg::REG_CODING_RATE_INDEX: cr_in  = csr_data[2:0];
            capc_pkg::REG_LOW_RATE_MODE:     ldr_in = csr_data[1:0];
            capc_pkg::REG_EXPLICIT_HEADER:   hdr_in = csr_data[0];
            capc_pkg::REG_PREAMBLE_SYMBOLS:  pre_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sf_ff  <= 4'd7;
         bw_ff  <= 9'd125;
         cr_ff  <= 3'd1;
         ldr_ff <= capc_pkg::LDR_AUTO;
         hdr_ff <= 1'b1;
         pre_ff <= 16'd8;
      end else begin
         sf_ff  <= sf_in;
         bw_ff  <= bw_in;
         cr_ff  <= cr_in;
         ldr_ff <= ldr_in;
         hdr_ff <= hdr_in;
         pre_ff <= pre_in;
      end
   end

   // Range limiting and the low data rate decision.
   always_comb begin
      cfg.sf  = (sf_ff < 4'd6) ? 4'd6 : ((sf_ff > 4'd12) ? 4'd12 : sf_ff);
      cfg.bw  = (bw_ff < 9'd7) ? 9'd7 : ((bw_ff > 9'd500) ? 9'd500 : bw_ff);
      cfg.cr  = (cr_ff < 3'd1) ? 3'd1 : ((cr_ff > 3'd4) ? 3'd4 : cr_ff);
      cfg.de  = (ldr_ff == capc_pkg::LDR_ON) ||
                ((ldr_ff == capc_pkg::LDR_AUTO) && (cfg.bw == 9'd125) &&
                 (cfg.sf >= 4'd11));
      cfg.h   = !hdr_ff;
      cfg.pre = pre_ff;
      divisor = {cfg.bw, 2'b00};
   end

   capc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_bytes  (req_payload_bytes),
      .in_ready  (front_ready),
      .out_valid (lane_valid[0]),
      .out_lane  (lane[0]),
      .out_ready (lane_ready[0])
   );

   assign req_stall = !front_ready;

   // Chain of division cells, one quotient bit each.
   for (genvar i = 0; i < W; i++) begin : g_cell
      capc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .divisor   (divisor),
         .in_valid  (lane_valid[i]),
         .in_lane   (lane[i]),
         .in_ready  (lane_ready[i]),
         .out_valid (lane_valid[i+1]),
         .out_lane  (lane[i+1]),
         .out_ready (lane_ready[i+1])
      );
   end

   assign lane_ready[W] = !rsp_stall;

   // Result fields with saturation of the wide quotients.
   assign q_ms = lane[W].dq_ms;
   assign q_us = lane[W].dq_us;
   assign rsp_valid           = lane_valid[W];
   assign rsp_payload_symbols = lane[W].ps;
   assign rsp_airtime_ms      = (|q_ms[W-1:32]) ? 32'hFFFF_FFFF : q_ms[31:0];
   assign rsp_airtime_us      = (|q_us[W-1:32]) ? 32'hFFFF_FFFF : q_us[31:0];

`ifndef SYNTH
   // The microsecond figure can never fall below the millisecond figure.
   a_us_not_below_ms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_airtime_us >= rsp_airtime_ms))
      else $error("airtime_us below airtime_ms");

   // Input is held off only when every stage of the chain is occupied.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&lane_valid) && rsp_stall))
      else $error("input stalled with a free stage in the chain");

   // The symbol count always carries the eight fixed symbols.
   a_symbols_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload_symbols >= 11'd8))
      else $error("payload symbol count below eight");

   // Reset empties the pipeline.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

### tb/sv/tb_chirp_packet_airtime_calc.sv
// ----------------------------------------------------------------------------
// tb_chirp_packet_airtime_calc: self-checking testbench for the airtime block
// Drives payload lengths into the block under several radio settings and
// checks each symbol count and time on air against a predictor kept in a
// small scoreboard class. Both sides of the stream idle and stall at random.
// One phase holds off the receiver long enough to fill the pipeline.
// ----------------------------------------------------------------------------
module tb_chirp_packet_airtime_calc;
   timeunit 1ns;
   timeprecision 1ps;

   // Indexes past the last register; writes there must change nothing.
   localparam logic [2:0] REG_UNMAPPED_LO = 3'd6;
   localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;
   // Mode code with no defined meaning; the block treats it as off.
   localparam logic [1:0] LDR_UNDEFINED   = 2'd3;

   localparam int DRAIN_CYCLES    = 60;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int CYCLE_LIMIT     = 300000;

   // One expected result of the block.
   typedef struct packed {
      logic [10:0] symbols;
      logic [31:0] ms;
      logic [31:0] us;
   } airtime_type;

   // Holds a copy of the registers, predicts each item's result and
   // compares the block's results in order.
   class airtime_scoreboard_type;
      logic [3:0]  sf_reg;
      logic [8:0]  bw_reg;
      logic [2:0]  cr_reg;
      logic [1:0]  ldr_reg;
      logic        hdr_reg;
      logic [15:0] pre_reg;
      airtime_type expected_airtimes[$];
      int          mismatch_count;

      function new();
         sf_reg         = 4'd7;
         bw_reg         = 9'd125;
         cr_reg         = 3'd1;
         ldr_reg        = capc_pkg::LDR_AUTO;
         hdr_reg        = 1'b1;
         pre_reg        = 16'd8;
         mismatch_count = 0;
      endfunction

      function void write_register(logic [2:0] index, logic [15:0] data);
         case (index)
            capc_pkg::REG_SPREADING_FACTOR:  sf_reg  = data[3:0];
            capc_pkg::REG_BANDWIDTH_KHZ:     bw_reg  = data[8:0];
            capc_pkg::REG_CODING_RATE_INDEX: cr_reg  = data[2:0];
            capc_pkg::REG_LOW_RATE_MODE:     ldr_reg = data[1:0];
            capc_pkg::REG_EXPLICIT_HEADER:   hdr_reg = data[0];
            capc_pkg::REG_PREAMBLE_SYMBOLS:  pre_reg = data;
            default: ;
         endcase
      endfunction

      function int clamp_range(int v, int lo, int hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function airtime_type predict_airtime(logic [7:0] bytes);
         airtime_type     r;
         int              sf, bw, cr, h, de, num, den, blocks, symbols;
         longint unsigned quarter, ms, us;
         sf = clamp_range(int'(sf_reg), 6, 12);
         bw = clamp_range(int'(bw_reg), 7, 500);
         cr = clamp_range(int'(cr_reg), 1, 4);
         h  = hdr_reg ? 0 : 1;
         // Low rate optimization: auto turns it on only for slow 125 kHz links.
         de = (ldr_reg == capc_pkg::LDR_ON ||
               (ldr_reg == capc_pkg::LDR_AUTO && bw == 125 && sf >= 11)) ? 1 : 0;
         num = 8 * int'(bytes) - 4 * sf + 44 - 20 * h;
         den = 4 * (sf - 2 * de);
         blocks = (num > 0) ? (num + den - 1) / den : 0;
         symbols = 8 + blocks * (cr + 4);
         // Time in quarter symbols scaled by the chips per symbol.
         quarter = longint'(4 * (int'(pre_reg) + symbols) + 17) << sf;
         ms = quarter / longint'(4 * bw);
         us = (quarter * 1000) / longint'(4 * bw);
         r.symbols = symbols[10:0];
         r.ms = (ms > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ms[31:0];
         r.us = (us > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : us[31:0];
         return r;
      endfunction

      task report_mismatch(string msg);
         mismatch_count++;
         $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      function void note_payload(logic [7:0] bytes);
         airtime_type p;
         p = predict_airtime(bytes);
         expected_airtimes.insert(expected_airtimes.size(), p);
      endfunction

      task check_airtime(logic [10:0] symbols, logic [31:0] ms, logic [31:0] us);
         airtime_type e;
         if (expected_airtimes.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, symbols %0d", symbols));
            return;
         end
         e = expected_airtimes[0];
         expected_airtimes.delete(0);
         if (symbols !== e.symbols)
            report_mismatch($sformatf("symbols %0d, expected %0d", symbols, e.symbols));
         if (ms !== e.ms)
            report_mismatch($sformatf("airtime_ms %0d, expected %0d", ms, e.ms));
         if (us !== e.us)
            report_mismatch($sformatf("airtime_us %0d, expected %0d", us, e.us));
      endtask
   endclass

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_stall;
   logic [7:0]  req_payload_bytes = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall         = 1'b0;
   logic [10:0] rsp_payload_symbols;
   logic [31:0] rsp_airtime_ms;
   logic [31:0] rsp_airtime_us;
   logic        csr_valid         = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index         = 3'd0;
   logic [15:0] csr_data          = 16'd0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_len      = 0;
   int cycle_count   = 0;

   airtime_scoreboard_type airtime_sb = new;

   chirp_packet_airtime_calc dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_payload_bytes   (req_payload_bytes),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_payload_symbols (rsp_payload_symbols),
      .rsp_airtime_ms      (rsp_airtime_ms),
      .rsp_airtime_us      (rsp_airtime_us),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Observe every handshake at the edge on which it completes.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            airtime_sb.write_register(csr_index, csr_data);
         if (req_valid && !req_stall)
            airtime_sb.note_payload(req_payload_bytes);
         if (rsp_valid && !rsp_stall)
            airtime_sb.check_airtime(rsp_payload_symbols, rsp_airtime_ms, rsp_airtime_us);
      end
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   initial begin : receiver
      int n;
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            for (n = 0; n < hold_len; n++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
            hold_len = 0;
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Offer one item, with random idle cycles ahead of it, until accepted.
   task automatic send_item(input logic [7:0] bytes);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_payload_bytes <= bytes;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop sending and wait until every expected result is back.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (airtime_sb.expected_airtimes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write; unused upper bits sometimes carry junk.
   task automatic csr_write(input logic [2:0] index, input int unsigned value, input int width);
      logic [15:0] data;
      data = 16'(value);
      if (width < 16 && $urandom_range(1) == 1)
         data = data | (16'($urandom) << width);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic apply_config(input int unsigned sf, input int unsigned bw,
                               input int unsigned cr, input logic [1:0] ldr,
                               input int unsigned hdr, input int unsigned pre);
      drain_pipeline();
      csr_write(capc_pkg::REG_SPREADING_FACTOR, sf, 4);
      csr_write(capc_pkg::REG_BANDWIDTH_KHZ, bw, 9);
      csr_write(capc_pkg::REG_CODING_RATE_INDEX, cr, 3);
      csr_write(capc_pkg::REG_LOW_RATE_MODE, ldr, 2);
      csr_write(capc_pkg::REG_EXPLICIT_HEADER, hdr, 1);
      csr_write(capc_pkg::REG_PREAMBLE_SYMBOLS, pre, 16);
      csr_write(REG_UNMAPPED_LO, $urandom_range(65535), 16);
      csr_write(REG_UNMAPPED_HI, $urandom_range(65535), 16);
      csr_valid <= 1'b0;
   endtask

   // Mostly legal settings, with the limits and out-of-range codes mixed in.
   task automatic apply_random_config();
      int unsigned sf, bw, cr, hdr, pre;
      logic [1:0]  ldr;
      sf = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(12, 6);
      case ($urandom_range(5))
         0:       bw = 7;
         1:       bw = 500;
         2:       bw = 125;
         3:       bw = $urandom_range(511);
         default: bw = $urandom_range(500, 7);
      endcase
      cr  = ($urandom_range(7) == 0) ? $urandom_range(7) : $urandom_range(4, 1);
      ldr = 2'($urandom_range(3));
      hdr = $urandom_range(1);
      case ($urandom_range(5))
         0:       pre = $urandom_range(65535);
         1:       pre = 65535;
         2:       pre = $urandom_range(5);
         default: pre = $urandom_range(64, 6);
      endcase
      apply_config(sf, bw, cr, ldr, hdr, pre);
   endtask

   function automatic logic [7:0] random_payload();
      case ($urandom_range(15))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   initial begin : stimulus
      int phase;
      int k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings, payload extremes and alternating bit patterns.
      send_item(8'h00);
      send_item(8'hFF);
      send_item(8'h55);
      send_item(8'hAA);
      // Auto low rate at 125 kHz and SF 12, implicit header, longest preamble:
      // an empty payload gives a negative numerator.
      apply_config(12, 125, 4, capc_pkg::LDR_AUTO, 0, 65535);
      send_item(8'h00);
      send_item(8'hFF);
      // Auto low rate at SF 11 with the shortest legal preamble.
      apply_config(11, 125, 1, capc_pkg::LDR_AUTO, 1, 6);
      send_item(8'd20);
      send_item(8'hFF);
      // Codes above their ranges, undefined low rate mode, empty preamble.
      apply_config(15, 511, 7, LDR_UNDEFINED, 1, 0);
      send_item(8'd100);
      send_item(8'hFF);
      // Codes below their ranges, forced low rate, short preamble.
      apply_config(0, 0, 0, capc_pkg::LDR_ON, 0, 5);
      send_item(8'h00);
      send_item(8'hFF);
      // Fastest setting with low rate off.
      apply_config(6, 500, 2, capc_pkg::LDR_OFF, 1, 65535);
      send_item(8'hFF);
      send_item(8'h01);
      // Slowest setting: the microsecond time saturates.
      apply_config(12, 7, 3, capc_pkg::LDR_ON, 1, 65535);
      send_item(8'hFF);
      send_item(8'h00);

      // Random phases, each under fresh settings.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < RANDOM_PHASES / 3) begin
            send_idle_pct = 11;
            rsp_stall_pct = 82;
         end else if (phase < 2 * RANDOM_PHASES / 3) begin
            send_idle_pct = 82;
            rsp_stall_pct = 11;
         end else begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         apply_random_config();
         // Hold off the receiver so the pipeline fills and stalls the input.
         if (phase == 2 * RANDOM_PHASES / 3)
            hold_len = 400;
         for (k = 0; k < ITEMS_PER_PHASE; k++)
            send_item(random_payload());
      end

      drain_pipeline();
      if (airtime_sb.mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
